// File: sv/srat_pkg.sv
// Package for the symbol register allocator table: sizes, codes and the entry type.
// Used by the channel interfaces, the entry memory and the top level.

package srat_pkg;

    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam int ACTION_W = 3;
    localparam int REG_W    = 6;
    localparam int CFG_W    = 5;
    localparam int OFF_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int IN_KEY_W = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INT    = 3'd0,
        ACT_STR    = 3'd1,
        ACT_LABEL  = 3'd2,
        ACT_LOOKUP = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOREG   = 2'd3
    } status_t;

    localparam logic          CFG_IDX_FIRST = 1'b0;
    localparam logic          CFG_IDX_LAST  = 1'b1;

    localparam logic [REG_W-1:0] NO_REG         = 6'h3F;
    localparam logic [REG_W-1:0] SKIP_LOW_REG   = 6'd1;
    localparam logic [REG_W-1:0] SKIP_HIGH_REG  = 6'd4;
    localparam logic [REG_W-1:0] FIRST_FREE_REG = 6'd5;
    localparam logic [CFG_W-1:0] FIRST_REG_RESET = 5'd5;
    localparam logic [CFG_W-1:0] LAST_REG_RESET  = 5'd31;

    localparam logic [OFF_W-1:0] NO_OFFSET  = 32'hFFFF_FFFF;
    localparam logic [OFF_W-1:0] INT_STRIDE = 32'd8;
    localparam logic [OFF_W-1:0] STR_STRIDE = 32'd64;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [REG_W-1:0]    reg_num;
        logic [OFF_W-1:0]    offset;
        logic                is_str;
    } srat_entry_t;

endpackage

// File: sv/srat_if.sv
// Valid/ready channel interfaces for the request and result words of the table.
// Depends on srat_pkg for the field widths.

interface srat_in_if
    import srat_pkg::*;
(
    input logic clk
);
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [IN_KEY_W-1:0] key;
    logic [SIZE_W-1:0]   label_size;

    modport source (input clk, output valid, output action, output key,
                    output label_size, input ready);
    modport sink   (input clk, input valid, input action, input key,
                    input label_size, output ready);
endinterface

interface srat_out_if
    import srat_pkg::*;
(
    input logic clk
);
    logic                    valid;
    logic                    ready;
    logic signed [REG_W-1:0] register_number;
    logic [OFF_W-1:0]        byte_offset;
    logic                    found;
    logic                    is_string;
    logic [STATUS_W-1:0]     status;

    modport source (input clk, output valid, output register_number,
                    output byte_offset, output found, output is_string,
                    output status, input ready);
    modport sink   (input clk, input valid, input register_number,
                    input byte_offset, input found, input is_string,
                    input status, output ready);
endinterface

// File: sv/srat_table_mem.sv
// Entry memory of the symbol table: one write port, one registered read port.
// Depends on srat_pkg for the depth and the entry layout.

module srat_table_mem
    import srat_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  srat_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output srat_entry_t       rd_data
);

    srat_entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/symbol_register_allocator_table_core.sv
// Top level of the symbol register allocator table.
// Depends on srat_pkg, the channel interfaces in srat_if.sv and srat_table_mem.

// The table holds up to ENTRIES symbols in a single-port-read memory and answers
// one request word at a time. A request is accepted only while the core is idle;
// clear and undefined actions then go straight to the decision, while every other
// action scans the stored entries oldest first, one memory read per cycle, and
// stops at the first key match. The result word is held in an output register, so
// the next request is accepted while a result still waits to be taken. A write
// to first_register takes effect at the next clear; last_register takes effect at
// once. The user must write configuration only while the core is idle; the core
// itself does not enforce this.

module symbol_register_allocator_table_core
    import srat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    srat_in_if.sink          req,
    srat_out_if.source       rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // Control sequencer: idle, search of the memory, then the decision and update.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [CFG_W-1:0] first_reg_reg, last_reg_reg;

    // Table bookkeeping.
    logic [CNT_W-1:0] count_reg, count_next;
    logic [REG_W-1:0] next_reg_reg, next_reg_next;
    logic [OFF_W-1:0] next_off_reg, next_off_next;

    // Search control.
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_reg, pend_next;
    logic             match_reg, match_next;

    // Captured request and first match.
    logic [ACTION_W-1:0] action_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [SIZE_W-1:0]   size_reg;
    srat_entry_t         hit_entry_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [REG_W-1:0]    out_reg_reg, out_reg_next;
    logic [OFF_W-1:0]    out_off_reg, out_off_next;
    logic                out_found_reg, out_found_next;
    logic                out_str_reg, out_str_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // Memory ports.
    logic        mem_wr_en;
    srat_entry_t mem_wr_data;
    logic        mem_rd_en;
    srat_entry_t mem_rd_data;

    logic in_fire;
    logic hit;
    logic slot_free;
    logic full;
    logic [REG_W-1:0] alloc_reg;
    logic             alloc_str;

    srat_table_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;

    // The read issued last cycle is compared against the request key here.
    assign hit       = pend_reg && (mem_rd_data.key == key_reg);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign full      = (count_reg >= CNT_W'(ENTRIES));
    assign alloc_str = (action_reg == ACT_STR);

    // Registers 1 to 4 are never handed out.
    assign alloc_reg = ((next_reg_reg >= SKIP_LOW_REG) && (next_reg_reg <= SKIP_HIGH_REG))
                       ? FIRST_FREE_REG : next_reg_reg;

    assign mem_rd_en = (state_reg == S_SCAN) && !hit && (scan_idx_reg < count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_reg_next   = next_reg_reg;
        next_off_next   = next_off_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        match_next      = match_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_reg_next    = out_reg_reg;
        out_off_next    = out_off_reg;
        out_found_next  = out_found_reg;
        out_str_next    = out_str_reg;
        out_status_next = out_status_reg;
        mem_wr_en       = 1'b0;
        mem_wr_data     = '{key: key_reg, reg_num: NO_REG, offset: next_off_reg, is_str: 1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    match_next    = 1'b0;
                    if (req.action == ACT_INT || req.action == ACT_STR ||
                        req.action == ACT_LABEL || req.action == ACT_LOOKUP)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_SCAN:
            begin
                priority if (hit)
                begin
                    match_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
                else if (scan_idx_reg >= count_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end

            S_DECIDE:
            begin
                if (slot_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_reg_next    = NO_REG;
                    out_off_next    = NO_OFFSET;
                    out_found_next  = match_reg;
                    out_str_next    = 1'b0;
                    out_status_next = ST_OK;

                    priority if (action_reg == ACT_CLEAR ||
                                 !(action_reg == ACT_INT || action_reg == ACT_STR ||
                                   action_reg == ACT_LABEL || action_reg == ACT_LOOKUP))
                    begin
                        // Clear and undefined actions share one fixed result.
                        out_off_next   = '0;
                        out_found_next = 1'b0;
                        if (action_reg == ACT_CLEAR)
                        begin
                            count_next    = '0;
                            next_reg_next = REG_W'(first_reg_reg);
                            next_off_next = '0;
                        end
                    end
                    else if (action_reg == ACT_LOOKUP)
                    begin
                        if (match_reg)
                        begin
                            out_reg_next = hit_entry_reg.reg_num;
                            out_off_next = hit_entry_reg.offset;
                            out_str_next = hit_entry_reg.is_str;
                        end
                    end
                    else if (action_reg == ACT_LABEL)
                    begin
                        priority if (match_reg)
                        begin
                            out_reg_next    = hit_entry_reg.reg_num;
                            out_off_next    = hit_entry_reg.offset;
                            out_str_next    = hit_entry_reg.is_str;
                            out_status_next = ST_PRESENT;
                        end
                        else if (full)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            out_off_next  = next_off_reg;
                            mem_wr_en     = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            next_off_next = next_off_reg + OFF_W'(size_reg);
                        end
                    end
                    else
                    begin
                        // Variable allocation; a label match still appends.
                        priority if (match_reg && (hit_entry_reg.reg_num != NO_REG))
                        begin
                            out_reg_next    = hit_entry_reg.reg_num;
                            out_off_next    = hit_entry_reg.offset;
                            out_str_next    = hit_entry_reg.is_str;
                            out_status_next = ST_PRESENT;
                        end
                        else if (full)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            next_reg_next = alloc_reg;
                            if (alloc_reg > REG_W'(last_reg_reg))
                            begin
                                out_status_next = ST_NOREG;
                            end
                            else
                            begin
                                out_reg_next  = alloc_reg;
                                out_off_next  = next_off_reg;
                                out_str_next  = alloc_str;
                                mem_wr_en     = 1'b1;
                                mem_wr_data   = '{key: key_reg, reg_num: alloc_reg,
                                                  offset: next_off_reg, is_str: alloc_str};
                                count_next    = count_reg + CNT_W'(1);
                                next_off_next = next_off_reg +
                                                (alloc_str ? STR_STRIDE : INT_STRIDE);
                                next_reg_next = alloc_reg + REG_W'(1);
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg_reg <= FIRST_REG_RESET;
            last_reg_reg  <= LAST_REG_RESET;
            count_reg     <= '0;
            next_reg_reg  <= REG_W'(FIRST_REG_RESET);
            next_off_reg  <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_reg_reg  <= next_reg_next;
            next_off_reg  <= next_off_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_IDX_FIRST: first_reg_reg <= cfg_data;
                    CFG_IDX_LAST:  last_reg_reg  <= cfg_data;
                    default:       first_reg_reg <= first_reg_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= req.action;
            key_reg    <= req.key[KEY_BITS-1:0];
            size_reg   <= req.label_size;
        end
        if (hit)
        begin
            hit_entry_reg <= mem_rd_data;
        end
        out_reg_reg    <= out_reg_next;
        out_off_reg    <= out_off_next;
        out_found_reg  <= out_found_next;
        out_str_reg    <= out_str_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.register_number = $signed(out_reg_reg);
    assign rsp.byte_offset     = out_off_reg;
    assign rsp.found           = out_found_reg;
    assign rsp.is_string       = out_str_reg;
    assign rsp.status          = out_status_reg;

endmodule
